>>> hdl/bmp24_pkg.sv
// Shared types and constants for the 24-bit BMP stream decoder.
// No dependencies; every other file of the block refers to this package.
package bmp24_pkg;

	localparam int FIELD_W = 20;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] ASCII_B = 8'h42;
	localparam logic [7:0] ASCII_M = 8'h4D;
	localparam logic [15:0] DEPTH_24 = 16'd24;
	localparam logic [5:0] HDR_LAST = 6'd53;
	localparam logic [5:0] HDR_POS_MAX = 6'd63;
	localparam logic [FIELD_W-1:0] MAX_DIM_RESET = 20'd100000;

	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_BAD = 2'd2,
		KIND_PREMATURE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_PIXEL = 2'd1,
		PH_IDLE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic first_byte;
		logic end_of_file;
	} in_item_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [FIELD_W-1:0] column_index;
		logic [FIELD_W-1:0] row_index;
		logic [FIELD_W-1:0] image_width;
		logic [FIELD_W-1:0] image_height;
		logic finished;
		logic last_of_run;
	} out_item_t;

	// One record per input byte that causes results. pos_a/pos_b carry the column and
	// row of a pixel or the width and height of an accepted header. tail asks for a
	// premature-end result to follow the first one.
	typedef struct packed {
		kind_t kind;
		logic tail;
		logic finished;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [FIELD_W-1:0] pos_a;
		logic [FIELD_W-1:0] pos_b;
	} rec_t;

endpackage

>>> hdl/bmp24_front.sv
// Front end of the BMP decoder: header parse, pixel assembly and padding skip.
// Depends on bmp24_pkg; emits one record per byte that causes results.
module bmp24_front #(
	parameter int DIM_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input bmp24_pkg::in_item_t item,
	input logic [bmp24_pkg::FIELD_W-1:0] max_dim,
	output logic rec_push,
	output bmp24_pkg::rec_t rec
);

	localparam logic [32:0] DimMax = (33'd1 << DIM_BITS) - 33'd1;

	bmp24_pkg::phase_t phase_q, phase_e, phase_n;
	logic [5:0] pos_q, pos_e, pos_n;
	logic [31:0] width_q, width_n;
	logic [31:0] height_q, height_n;
	logic [15:0] depth_q, depth_n;
	logic [DIM_BITS-1:0] col_q, col_e, col_n;
	logic [DIM_BITS-1:0] row_q, row_e, row_n;
	logic [1:0] pbi_q, pbi_e, pbi_n;
	logic [1:0] pad_q, pad_e, pad_n;
	logic [7:0] blue_q, blue_n;
	logic [7:0] green_q, green_n;

	logic [DIM_BITS:0] col_inc, row_inc, width_d, height_d;
	logic row_done, last_row, end_row, bad, hdr_ok, empty_img, emit;
	logic [7:0] b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bmp24_pkg::PH_HEADER;
			pos_q <= '0;
			width_q <= '0;
			height_q <= '0;
			depth_q <= '0;
			col_q <= '0;
			row_q <= '0;
			pbi_q <= '0;
			pad_q <= '0;
			blue_q <= '0;
			green_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			pos_q <= pos_n;
			width_q <= width_n;
			height_q <= height_n;
			depth_q <= depth_n;
			col_q <= col_n;
			row_q <= row_n;
			pbi_q <= pbi_n;
			pad_q <= pad_n;
			blue_q <= blue_n;
			green_q <= green_n;
		end
	end

	// A first-byte mark restarts the parse as if the state had just been cleared.
	assign phase_e = item.first_byte ? bmp24_pkg::PH_HEADER : phase_q;
	assign pos_e = item.first_byte ? 6'd0 : pos_q;
	assign col_e = item.first_byte ? '0 : col_q;
	assign row_e = item.first_byte ? '0 : row_q;
	assign pbi_e = item.first_byte ? 2'd0 : pbi_q;
	assign pad_e = item.first_byte ? 2'd0 : pad_q;
	assign b = item.data_byte;

	assign col_inc = {1'b0, col_e} + {{DIM_BITS{1'b0}}, 1'b1};
	assign row_inc = {1'b0, row_e} + {{DIM_BITS{1'b0}}, 1'b1};
	assign width_d = {1'b0, width_q[DIM_BITS-1:0]};
	assign height_d = {1'b0, height_q[DIM_BITS-1:0]};
	assign row_done = col_inc >= width_d;
	assign last_row = row_inc >= height_d;

	assign hdr_ok = (depth_q == bmp24_pkg::DEPTH_24)
		&& (width_q <= 32'(max_dim)) && (height_q <= 32'(max_dim))
		&& ({1'b0, width_q} <= DimMax) && ({1'b0, height_q} <= DimMax);
	assign empty_img = (width_q == '0) || (height_q == '0);

	always_comb begin
		phase_n = phase_e;
		pos_n = pos_e;
		width_n = width_q;
		height_n = height_q;
		depth_n = depth_q;
		col_n = col_e;
		row_n = row_e;
		pbi_n = pbi_e;
		pad_n = pad_e;
		blue_n = blue_q;
		green_n = green_q;
		emit = 1'b0;
		bad = 1'b0;
		end_row = 1'b0;
		rec = '0;

		case (phase_e)
			bmp24_pkg::PH_HEADER: begin
				case (pos_e)
					6'd0: bad = (b != bmp24_pkg::ASCII_B);
					6'd1: bad = (b != bmp24_pkg::ASCII_M);
					6'd18: width_n[7:0] = b;
					6'd19: width_n[15:8] = b;
					6'd20: width_n[23:16] = b;
					6'd21: width_n[31:24] = b;
					6'd22: height_n[7:0] = b;
					6'd23: height_n[15:8] = b;
					6'd24: height_n[23:16] = b;
					6'd25: height_n[31:24] = b;
					6'd28: depth_n[7:0] = b;
					6'd29: depth_n[15:8] = b;
					default: ;
				endcase
				if (!bad && pos_e == bmp24_pkg::HDR_LAST) begin
					if (hdr_ok) begin
						emit = 1'b1;
						rec.kind = bmp24_pkg::KIND_HEADER;
						rec.pos_a = width_q[bmp24_pkg::FIELD_W-1:0];
						rec.pos_b = height_q[bmp24_pkg::FIELD_W-1:0];
						rec.finished = empty_img;
						rec.tail = !empty_img && item.end_of_file;
						phase_n = (empty_img || item.end_of_file) ? bmp24_pkg::PH_IDLE
							: bmp24_pkg::PH_PIXEL;
					end else begin
						bad = 1'b1;
					end
				end else if (!bad && item.end_of_file) begin
					bad = 1'b1;
				end
				if (bad) begin
					emit = 1'b1;
					rec.kind = bmp24_pkg::KIND_BAD;
					phase_n = bmp24_pkg::PH_IDLE;
				end
				if (pos_e != bmp24_pkg::HDR_POS_MAX) begin
					pos_n = pos_e + 6'd1;
				end
			end
			bmp24_pkg::PH_PIXEL: begin
				if (pad_e != 2'd0) begin
					pad_n = pad_e - 2'd1;
					end_row = (pad_e == 2'd1);
				end else begin
					case (pbi_e)
						2'd0: begin
							blue_n = b;
							pbi_n = 2'd1;
						end
						2'd1: begin
							green_n = b;
							pbi_n = 2'd2;
						end
						default: begin
							emit = 1'b1;
							rec.kind = bmp24_pkg::KIND_PIXEL;
							rec.red = b;
							rec.green = green_q;
							rec.blue = blue_q;
							rec.pos_a = bmp24_pkg::FIELD_W'(col_e);
							rec.pos_b = bmp24_pkg::FIELD_W'(row_e);
							rec.finished = row_done && last_row;
							pbi_n = 2'd0;
							col_n = col_inc[DIM_BITS-1:0];
							if (row_done) begin
								pad_n = width_q[1:0];
								end_row = (width_q[1:0] == 2'd0);
							end
						end
					endcase
				end
				if (end_row) begin
					col_n = '0;
					row_n = row_inc[DIM_BITS-1:0];
					if (last_row) begin
						phase_n = bmp24_pkg::PH_IDLE;
					end
				end
				if (item.end_of_file && phase_n == bmp24_pkg::PH_PIXEL) begin
					phase_n = bmp24_pkg::PH_IDLE;
					if (emit) begin
						rec.tail = 1'b1;
					end else begin
						emit = 1'b1;
						rec.kind = bmp24_pkg::KIND_PREMATURE;
					end
				end
			end
			default: ;
		endcase
	end

	assign rec_push = accept && emit;

	hdr_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bmp24_pkg::PH_HEADER) |-> (pos_q <= bmp24_pkg::HDR_LAST))
		else $error("header position ran past the last header byte");

	pad_only_between_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_q != 2'd0) |-> (pbi_q == 2'd0))
		else $error("row padding pending in the middle of a pixel");

endmodule

>>> hdl/bmp24_queue.sv
// Short record queue between the parsing front end and the result back end.
// Depends on bmp24_pkg for the record type and the depth.
module bmp24_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input bmp24_pkg::rec_t wr_rec,
	output logic full,
	input logic deq,
	output bmp24_pkg::rec_t rd_rec,
	output logic q_empty
);

	localparam logic [bmp24_pkg::QCNT_W-1:0] Depth = bmp24_pkg::QCNT_W'(bmp24_pkg::QUEUE_DEPTH);
	localparam logic [bmp24_pkg::QPTR_W-1:0] PtrOne = bmp24_pkg::QPTR_W'(1);
	localparam logic [bmp24_pkg::QCNT_W-1:0] CntOne = bmp24_pkg::QCNT_W'(1);

	bmp24_pkg::rec_t slot_q [bmp24_pkg::QUEUE_DEPTH];
	logic [bmp24_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [bmp24_pkg::QCNT_W-1:0] count_q;
	logic do_push, do_deq;

	assign do_push = push && !full;
	assign do_deq = deq && !q_empty;
	assign full = (count_q == Depth);
	assign q_empty = (count_q == '0);
	assign rd_rec = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PtrOne;
			end
			if (do_deq) begin
				rd_ptr_q <= rd_ptr_q + PtrOne;
			end
			case ({do_push, do_deq})
				2'b10: count_q <= count_q + CntOne;
				2'b01: count_q <= count_q - CntOne;
				default: ;
			endcase
		end
	end

	count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Depth)
		else $error("record queue count beyond its depth");

	no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("record pushed into a full queue");

endmodule

>>> hdl/bmp24_back.sv
// Back end of the BMP decoder: expands queued records into result items.
// Depends on bmp24_pkg; holds the output register seen by the result channel.
module bmp24_back (
	input logic clk,
	input logic arst_n,
	input bmp24_pkg::rec_t rd_rec,
	input logic q_empty,
	output logic deq,
	input logic pop,
	output logic empty,
	output bmp24_pkg::out_item_t result
);

	bmp24_pkg::out_item_t out_q, first_item, tail_item;
	logic valid_q, tail_pending_q, out_free;

	assign out_free = !valid_q || pop;
	assign deq = out_free && !tail_pending_q && !q_empty;
	assign empty = !valid_q;
	assign result = out_q;

	always_comb begin
		first_item = '0;
		first_item.kind = rd_rec.kind;
		first_item.finished = rd_rec.finished;
		first_item.last_of_run = !rd_rec.tail;
		case (rd_rec.kind)
			bmp24_pkg::KIND_PIXEL: begin
				first_item.red = rd_rec.red;
				first_item.green = rd_rec.green;
				first_item.blue = rd_rec.blue;
				first_item.column_index = rd_rec.pos_a;
				first_item.row_index = rd_rec.pos_b;
			end
			bmp24_pkg::KIND_HEADER: begin
				first_item.image_width = rd_rec.pos_a;
				first_item.image_height = rd_rec.pos_b;
			end
			default: ;
		endcase
		tail_item = '0;
		tail_item.kind = bmp24_pkg::KIND_PREMATURE;
		tail_item.last_of_run = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= tail_pending_q ? tail_item : first_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tail_pending_q <= 1'b0;
		end else if (out_free) begin
			if (tail_pending_q) begin
				valid_q <= 1'b1;
				tail_pending_q <= 1'b0;
			end else begin
				valid_q <= !q_empty;
				tail_pending_q <= !q_empty && rd_rec.tail;
			end
		end
	end

	tail_follows_open_run: assert property (@(posedge clk) disable iff (!arst_n)
		tail_pending_q |-> (valid_q && !out_q.last_of_run))
		else $error("premature-end tail pending without an open run");

	tail_is_premature_end: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_pending_q && pop) |=> (valid_q && out_q.kind == bmp24_pkg::KIND_PREMATURE))
		else $error("tail result is not a premature end");

endmodule

>>> hdl/bmp24_stream_decoder.sv
// Top level of the 24-bit BMP stream decoder.
// Depends on bmp24_pkg and instantiates bmp24_front, bmp24_queue and bmp24_back.
//
// The file arrives one byte per transfer on the input queue port: an item is taken
// at a clock edge where push is high and full is low. The item carries the byte, a
// first-byte mark that restarts the parse and an end-of-file mark. Results leave
// through the output queue port: the oldest result sits on result while empty is
// low, and a transfer completes at an edge where pop is high and empty is low.
// A byte that causes results writes its record into the record queue at its transfer;
// the back end moves its results on to the output register. The block takes one byte
// every cycle while full is low; the front end parses a byte in the cycle it arrives,
// and a four-record queue absorbs the back end's stalls. A byte with two results (a
// premature end after a pixel or a header) holds the back end until its second result
// is in the output register. When the receiver stops popping, the queue fills and
// full rises; no result is lost. The max_dimension register is written through
// cfg_valid/cfg_data; cfg_ready is always high, and writes belong in idle periods.
// Reset sets max_dimension to 100000, empties the queue and the output register and
// makes the next byte byte 0 of a file.
module bmp24_stream_decoder #(
	parameter int DIM_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input bmp24_pkg::in_item_t item,
	output logic empty,
	input logic pop,
	output bmp24_pkg::out_item_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [bmp24_pkg::FIELD_W-1:0] cfg_data
);

	logic [bmp24_pkg::FIELD_W-1:0] max_dim_q;
	logic accept, rec_push, q_empty, deq;
	bmp24_pkg::rec_t wr_rec, rd_rec;

	// The configuration register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dim_q <= bmp24_pkg::MAX_DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_dim_q <= cfg_data;
		end
	end

	// Input transfer: the front end's state advances only on accepted bytes.
	assign accept = push && !full;

	bmp24_front #(
		.DIM_BITS(DIM_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(item),
		.max_dim(max_dim_q),
		.rec_push(rec_push),
		.rec(wr_rec)
	);

	// Only bytes that cause results enter the queue; header and colour bytes
	// before a pixel's red byte leave no record.
	bmp24_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(rec_push),
		.wr_rec(wr_rec),
		.full(full),
		.deq(deq),
		.rd_rec(rd_rec),
		.q_empty(q_empty)
	);

	bmp24_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rd_rec(rd_rec),
		.q_empty(q_empty),
		.deq(deq),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

	result_follows_record: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |=> ##1 !empty)
		else $error("a pushed record produced no visible result");

endmodule

>>> tb/tb.sv
// Self-checking testbench for bmp24_stream_decoder: directed BMP files, then random files.
// Depends on bmp24_pkg for the item types, kind and phase codes and header constants.
// Carries its own byte-level decoder to predict every result that the block returns.
module tb;

	localparam int SETTLE = 8;
	localparam int RUN_LIMIT = 200000;
	localparam int PHASE_BYTES = 30;

	// One BMP file to send. A stop of zero sends the whole file; known rows carry the
	// single result that the file must produce, written out by hand.
	typedef struct {
		bit mark;
		logic [7:0] m0;
		logic [7:0] m1;
		logic [31:0] wid;
		logic [31:0] hgt;
		logic [15:0] dep;
		int stop;
		bit eof;
		int extra;
		bit known;
		bmp24_pkg::out_item_t want;
	} bmp_file_t;

	// Parse state of the decoder being predicted. Counters are kept wide so that the
	// compares against the 32-bit header sizes are exact.
	typedef struct {
		bmp24_pkg::phase_t ph;
		logic [5:0] hpos;
		logic [31:0] wid;
		logic [31:0] hgt;
		logic [15:0] dep;
		logic [31:0] col;
		logic [31:0] row;
		logic [1:0] bidx;
		logic [7:0] hb;
		logic [7:0] hg;
		logic [1:0] pad;
	} parse_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	bmp24_pkg::in_item_t item;
	logic empty;
	logic pop;
	bmp24_pkg::out_item_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [bmp24_pkg::FIELD_W-1:0] cfg_data;

	parse_t st;
	logic [bmp24_pkg::FIELD_W-1:0] max_dim;
	bmp24_pkg::out_item_t byte_results[$];
	bmp24_pkg::out_item_t decoded_queue[$];
	bmp_file_t directed_files[$];
	bit typed_armed;
	bmp24_pkg::out_item_t typed_want;
	bit send_calm;
	bit take_calm;
	int errors = 0;
	int cycles = 0;
	int bytes_sent = 0;
	int files_sent = 0;
	int results_seen = 0;
	int kind_seen[4] = '{0, 0, 0, 0};

	bmp24_stream_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic bmp24_pkg::out_item_t make_result(bmp24_pkg::kind_t k,
			logic [7:0] r, logic [7:0] g, logic [7:0] bl, logic [19:0] col,
			logic [19:0] row, logic [19:0] w, logic [19:0] h, logic fin);
		bmp24_pkg::out_item_t o;
		o.kind = k;
		o.red = r;
		o.green = g;
		o.blue = bl;
		o.column_index = col;
		o.row_index = row;
		o.image_width = w;
		o.image_height = h;
		o.finished = fin;
		o.last_of_run = 1'b0;
		return o;
	endfunction

	function automatic void add(bmp24_pkg::kind_t k, logic [7:0] r, logic [7:0] g,
			logic [7:0] bl, logic [19:0] col, logic [19:0] row, logic [19:0] w,
			logic [19:0] h, logic fin);
		byte_results.push_back(make_result(k, r, g, bl, col, row, w, h, fin));
	endfunction

	function automatic void clear_parse();
		st.ph = bmp24_pkg::PH_HEADER;
		st.hpos = '0;
		st.wid = '0;
		st.hgt = '0;
		st.dep = '0;
		st.col = '0;
		st.row = '0;
		st.bidx = '0;
		st.hb = '0;
		st.hg = '0;
		st.pad = '0;
	endfunction

	function automatic void close_row();
		st.col = '0;
		st.row = st.row + 1;
		if (st.row >= st.hgt)
			st.ph = bmp24_pkg::PH_IDLE;
	endfunction

	// Predicts the results of one accepted byte into byte_results.
	function automatic void decode_byte(bmp24_pkg::in_item_t b);
		logic [7:0] d;
		int unsigned p;
		logic bad;
		logic ok;
		logic empty_img;
		logic row_done;
		logic last;
		bmp24_pkg::out_item_t tail;
		d = b.data_byte;
		byte_results.delete();
		if (b.first_byte)
			clear_parse();
		if (st.ph == bmp24_pkg::PH_HEADER) begin
			p = st.hpos;
			bad = 1'b0;
			if (p == 0 && d != bmp24_pkg::ASCII_B)
				bad = 1'b1;
			else if (p == 1 && d != bmp24_pkg::ASCII_M)
				bad = 1'b1;
			else if (p >= 18 && p <= 21)
				st.wid = st.wid | (32'(d) << (8 * (p - 18)));
			else if (p >= 22 && p <= 25)
				st.hgt = st.hgt | (32'(d) << (8 * (p - 22)));
			else if (p >= 28 && p <= 29)
				st.dep = st.dep | (16'(d) << (8 * (p - 28)));

			if (!bad && p == bmp24_pkg::HDR_LAST) begin
				// The limit is 20 bits wide, so it also keeps the sizes within the
				// block's field width.
				ok = st.dep == bmp24_pkg::DEPTH_24 && st.wid <= {12'd0, max_dim} &&
					st.hgt <= {12'd0, max_dim};
				if (ok) begin
					empty_img = st.wid == 0 || st.hgt == 0;
					add(bmp24_pkg::KIND_HEADER, 0, 0, 0, 0, 0, st.wid[19:0], st.hgt[19:0],
						empty_img);
					st.ph = empty_img ? bmp24_pkg::PH_IDLE : bmp24_pkg::PH_PIXEL;
					if (!empty_img && b.end_of_file) begin
						add(bmp24_pkg::KIND_PREMATURE, 0, 0, 0, 0, 0, 0, 0, 1'b0);
						st.ph = bmp24_pkg::PH_IDLE;
					end
				end else begin
					bad = 1'b1;
				end
			end else if (!bad && b.end_of_file) begin
				bad = 1'b1;
			end
			if (bad) begin
				add(bmp24_pkg::KIND_BAD, 0, 0, 0, 0, 0, 0, 0, 1'b0);
				st.ph = bmp24_pkg::PH_IDLE;
			end
			if (st.hpos < bmp24_pkg::HDR_POS_MAX)
				st.hpos = st.hpos + 1;
		end else if (st.ph == bmp24_pkg::PH_PIXEL) begin
			if (st.pad != 0) begin
				st.pad = st.pad - 1;
				if (st.pad == 0)
					close_row();
			end else if (st.bidx == 0) begin
				st.hb = d;
				st.bidx = 1;
			end else if (st.bidx == 1) begin
				st.hg = d;
				st.bidx = 2;
			end else begin
				// Red byte: the pixel is complete.
				row_done = st.col + 1 >= st.wid;
				last = row_done && st.row + 1 >= st.hgt;
				add(bmp24_pkg::KIND_PIXEL, d, st.hg, st.hb, st.col[19:0], st.row[19:0],
					0, 0, last);
				st.bidx = 0;
				st.col = st.col + 1;
				if (row_done) begin
					// Rows are padded by width mod 4 bytes, which rounds 3*width up to
					// a multiple of four.
					st.pad = st.wid[1:0];
					if (st.pad == 0)
						close_row();
				end
			end
			if (b.end_of_file && st.ph == bmp24_pkg::PH_PIXEL) begin
				add(bmp24_pkg::KIND_PREMATURE, 0, 0, 0, 0, 0, 0, 0, 1'b0);
				st.ph = bmp24_pkg::PH_IDLE;
			end
		end
		if (byte_results.size() != 0) begin
			tail = byte_results.pop_back();
			tail.last_of_run = 1'b1;
			byte_results.push_back(tail);
		end
	endfunction

	// Full length of a file: the header, then each row of pixels with its padding.
	// Files with large sizes are cut after the header.
	function automatic int file_len(bmp_file_t f);
		if (f.stop != 0)
			return f.stop;
		if (f.wid > 64 || f.hgt > 64)
			return 54;
		return 54 + int'(f.hgt) * (3 * int'(f.wid) + int'(f.wid[1:0]));
	endfunction

	task automatic add_case(bit mark, logic [7:0] m0, logic [7:0] m1, logic [31:0] wid,
			logic [31:0] hgt, logic [15:0] dep, int stop, bit eof, int extra, bit known,
			bmp24_pkg::kind_t k, logic [19:0] w, logic [19:0] h, logic fin);
		bmp_file_t f;
		f.mark = mark;
		f.m0 = m0;
		f.m1 = m1;
		f.wid = wid;
		f.hgt = hgt;
		f.dep = dep;
		f.stop = stop;
		f.eof = eof;
		f.extra = extra;
		f.known = known;
		f.want = make_result(k, 0, 0, 0, 0, 0, w, h, fin);
		f.want.last_of_run = 1'b1;
		directed_files.push_back(f);
	endtask

	// Sends one byte over the input queue port and records its predicted results. The
	// push line is left high, so that a following byte may go out without a gap.
	task automatic transfer(bmp24_pkg::in_item_t b);
		int gap;
		if ($urandom_range(0, 31) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= b;
		do @(posedge clk); while (full);
		bytes_sent++;
		decode_byte(b);
		if (typed_armed && byte_results.size() != 0) begin
			decoded_queue.push_back(typed_want);
			typed_armed = 1'b0;
		end else if (!typed_armed) begin
			foreach (byte_results[i])
				decoded_queue.push_back(byte_results[i]);
		end
	endtask

	task automatic send_file(bmp_file_t f);
		int len;
		bmp24_pkg::in_item_t b;
		len = file_len(f);
		typed_armed = f.known;
		typed_want = f.want;
		for (int pos = 0; pos < len; pos++) begin
			b.data_byte = 8'($urandom);
			case (pos)
				0: b.data_byte = f.m0;
				1: b.data_byte = f.m1;
				18, 19, 20, 21: b.data_byte = f.wid[8 * (pos - 18) +: 8];
				22, 23, 24, 25: b.data_byte = f.hgt[8 * (pos - 22) +: 8];
				28, 29: b.data_byte = f.dep[8 * (pos - 28) +: 8];
				default: ;
			endcase
			b.first_byte = pos == 0 && f.mark;
			b.end_of_file = pos == len - 1 && f.eof;
			transfer(b);
		end
		// A hand-written result that never got matched to a byte still has to arrive.
		if (typed_armed) begin
			decoded_queue.push_back(typed_want);
			typed_armed = 1'b0;
		end
		for (int k = 0; k < f.extra; k++) begin
			b.data_byte = 8'($urandom);
			b.first_byte = 1'b0;
			b.end_of_file = 1'($urandom);
			transfer(b);
		end
		files_sent++;
	endtask

	// Holds the sender off until every predicted result has been taken, then lets the
	// block settle.
	task automatic drain();
		push <= 1'b0;
		while (decoded_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(logic [bmp24_pkg::FIELD_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_dim = v;
	endtask

	task automatic note(string field, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
		end
	endtask

	task automatic compare_result(bmp24_pkg::out_item_t got);
		bmp24_pkg::out_item_t want;
		results_seen++;
		if (!$isunknown(got.kind))
			kind_seen[got.kind]++;
		if (decoded_queue.size() == 0) begin
			errors++;
			$display("%0t: result %h arrived with nothing expected", $time, got);
		end else begin
			want = decoded_queue.pop_front();
			note("kind", want.kind, got.kind);
			note("red", want.red, got.red);
			note("green", want.green, got.green);
			note("blue", want.blue, got.blue);
			note("column_index", want.column_index, got.column_index);
			note("row_index", want.row_index, got.row_index);
			note("image_width", want.image_width, got.image_width);
			note("image_height", want.image_height, got.image_height);
			note("finished", want.finished, got.finished);
			note("last_of_run", want.last_of_run, got.last_of_run);
		end
	endtask

	// Result side: a random stall before each transfer, with calm stretches.
	initial begin
		int gap;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 31) == 0)
				take_calm = !take_calm;
			gap = take_calm ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			compare_result(result);
		end
	end

	initial begin
		logic [bmp24_pkg::FIELD_W-1:0] limits[3];
		bmp_file_t f;
		bmp24_pkg::in_item_t b;
		int start;
		int pick;
		int cap;
		logic [31:0] over;

		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		send_calm = 1'b0;
		take_calm = 1'b0;
		typed_armed = 1'b0;
		max_dim = bmp24_pkg::MAX_DIM_RESET;
		clear_parse();

		// Directed files at the reset limit. The first one has no first-byte mark; it is
		// complete, has no row padding and is followed by bytes that must be ignored.
		//       mark m0 m1 width height depth stop eof ext known
		add_case(0, bmp24_pkg::ASCII_B, bmp24_pkg::ASCII_M, 4, 1, bmp24_pkg::DEPTH_24,
			0, 1, 3, 0, bmp24_pkg::KIND_PIXEL, 0, 0, 0);
		add_case(1, 8'h00, bmp24_pkg::ASCII_M, 1, 1, bmp24_pkg::DEPTH_24,
			1, 1, 0, 1, bmp24_pkg::KIND_BAD, 0, 0, 0);
		add_case(1, bmp24_pkg::ASCII_B, 8'h6D, 1, 1, bmp24_pkg::DEPTH_24,
			2, 1, 0, 1, bmp24_pkg::KIND_BAD, 0, 0, 0);
		add_case(1, bmp24_pkg::ASCII_B, bmp24_pkg::ASCII_M, 100000, 0, bmp24_pkg::DEPTH_24,
			0, 1, 0, 1, bmp24_pkg::KIND_HEADER, 100000, 0, 1);
		add_case(1, bmp24_pkg::ASCII_B, bmp24_pkg::ASCII_M, 100001, 1, bmp24_pkg::DEPTH_24,
			0, 1, 0, 1, bmp24_pkg::KIND_BAD, 0, 0, 0);
		// Header cut short, and a file that ends on its very first byte.
		add_case(1, bmp24_pkg::ASCII_B, bmp24_pkg::ASCII_M, 2, 2, bmp24_pkg::DEPTH_24,
			10, 1, 0, 1, bmp24_pkg::KIND_BAD, 0, 0, 0);
		add_case(1, bmp24_pkg::ASCII_B, bmp24_pkg::ASCII_M, 2, 2, bmp24_pkg::DEPTH_24,
			1, 1, 0, 1, bmp24_pkg::KIND_BAD, 0, 0, 0);
		// End of file on the last header byte: header accepted, then premature end.
		add_case(1, bmp24_pkg::ASCII_B, bmp24_pkg::ASCII_M, 3, 2, bmp24_pkg::DEPTH_24,
			54, 1, 0, 0, bmp24_pkg::KIND_PIXEL, 0, 0, 0);
		// Only the final padding byte is missing.
		add_case(1, bmp24_pkg::ASCII_B, bmp24_pkg::ASCII_M, 1, 1, bmp24_pkg::DEPTH_24,
			57, 1, 0, 0, bmp24_pkg::KIND_PIXEL, 0, 0, 0);
		// Abandoned in the pixel data after a padded row; the next mark restarts.
		add_case(1, bmp24_pkg::ASCII_B, bmp24_pkg::ASCII_M, 2, 2, bmp24_pkg::DEPTH_24,
			62, 0, 0, 0, bmp24_pkg::KIND_PIXEL, 0, 0, 0);
		// Ends on the byte that completes a pixel.
		add_case(1, bmp24_pkg::ASCII_B, bmp24_pkg::ASCII_M, 3, 1, bmp24_pkg::DEPTH_24,
			60, 1, 0, 0, bmp24_pkg::KIND_PIXEL, 0, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_files[i])
			send_file(directed_files[i]);

		// Random files under several limits, the extremes among them.
		limits = '{20'hFFFFF, 20'd0, 20'd3};
		foreach (limits[s]) begin
			write_limit(limits[s]);
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES) begin
				pick = $urandom_range(0, 9);
				if (pick == 9) begin
					// Noise: raw bytes with random marks.
					repeat ($urandom_range(1, 4)) begin
						b.data_byte = 8'($urandom);
						b.first_byte = $urandom_range(0, 3) == 0;
						b.end_of_file = 1'($urandom);
						transfer(b);
					end
				end else begin
					f.mark = 1'b1;
					f.m0 = bmp24_pkg::ASCII_B;
					f.m1 = bmp24_pkg::ASCII_M;
					f.dep = bmp24_pkg::DEPTH_24;
					f.stop = 0;
					f.eof = 1'b1;
					f.extra = $urandom_range(0, 2);
					f.known = 1'b0;
					f.want = '0;
					cap = max_dim < 6 ? int'(max_dim) : 6;
					f.wid = $urandom_range(0, cap);
					f.hgt = $urandom_range(0, cap < 3 ? cap : 3);
					case (pick)
						6: begin
							case ($urandom_range(0, 2))
								0: begin
									f.m0 = 8'($urandom);
									if (f.m0 == bmp24_pkg::ASCII_B)
										f.m0 = ~f.m0;
								end
								1: begin
									f.m1 = 8'($urandom);
									if (f.m1 == bmp24_pkg::ASCII_M)
										f.m1 = ~f.m1;
								end
								default: f.dep = 16'($urandom);
							endcase
						end
						7: begin
							over = max_dim == '1 ? (32'h0010_0000 | $urandom) :
								{12'd0, max_dim} + 1;
							if ($urandom_range(0, 1))
								f.wid = over;
							else
								f.hgt = over;
						end
						8: begin
							// A size right at the limit; the pixel data is cut short.
							if ($urandom_range(0, 1)) begin
								f.wid = {12'd0, max_dim};
								f.hgt = $urandom_range(0, 1);
							end else begin
								f.hgt = {12'd0, max_dim};
								f.wid = $urandom_range(0, 1);
							end
							f.stop = 54 + $urandom_range(0, 8);
							f.eof = 1'($urandom);
						end
						default: begin
							case ($urandom_range(0, 3))
								0: f.stop = $urandom_range(1, file_len(f));
								1: begin
									f.stop = $urandom_range(1, file_len(f));
									f.eof = 1'b0;
								end
								default: f.eof = $urandom_range(0, 3) != 0;
							endcase
						end
					endcase
					send_file(f);
				end
				if ($urandom_range(0, 7) == 0)
					drain();
			end
		end

		drain();
		$display("tb: %0d bytes in %0d files under %0d limit settings, %0d results checked",
			bytes_sent, files_sent, $size(limits) + 1, results_seen);
		$display("tb: %0d pixels, %0d headers, %0d bad formats, %0d premature ends",
			kind_seen[bmp24_pkg::KIND_PIXEL], kind_seen[bmp24_pkg::KIND_HEADER],
			kind_seen[bmp24_pkg::KIND_BAD], kind_seen[bmp24_pkg::KIND_PREMATURE]);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
